[sv/ric_pkg.sv]
// types, constants and key handling shared by the route indicator controller
package ric_pkg;

  localparam int FRAME_LAMPS = 40;

  // chime step boundaries
  localparam logic [8:0] CHIME_END      = 9'd277;
  localparam logic [8:0] HIGH1_END      = 9'd40;
  localparam logic [8:0] LOW1_END       = 9'd93;
  localparam logic [8:0] HIGH2_START    = 9'd184;
  localparam logic [8:0] LOW2_START     = 9'd224;

  // tone settings for the two chime kinds
  localparam logic [7:0] HIGH_PERIOD_0  = 8'd112;
  localparam logic [7:0] HIGH_PERIOD_1  = 8'd105;
  localparam logic [7:0] HIGH_CMP_0     = 8'd56;
  localparam logic [7:0] HIGH_CMP_1     = 8'd53;
  localparam logic [7:0] LOW_PERIOD_0   = 8'd149;
  localparam logic [7:0] LOW_PERIOD_1   = 8'd141;
  localparam logic [7:0] LOW_CMP_0      = 8'd75;
  localparam logic [7:0] LOW_CMP_1      = 8'd71;
  localparam logic [7:0] RESET_PERIOD   = 8'd99;

  // station limits
  localparam logic [4:0] FIRST_STATION  = 5'd1;
  localparam logic [4:0] LAST_STATION   = 5'd19;

  // tick commands
  localparam logic CMD_CHIME   = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  // button functions, in handling order
  typedef enum logic [2:0] {
    KEY_DOOR    = 3'd0,
    KEY_CHIME1  = 3'd1,
    KEY_CHIME2  = 3'd2,
    KEY_FWD     = 3'd3,
    KEY_REVERSE = 3'd4,
    KEY_BACK    = 3'd5
  } key_t;

  typedef struct packed {
    logic       cmd;
    logic [5:0] buttons_n;
  } tick_t;

  typedef struct packed {
    logic [FRAME_LAMPS-1:0] lamp_frame;
    logic                   door_lamp;
    logic                   arrow_a;
    logic                   arrow_b;
    logic [7:0]             tone_period;
    logic [7:0]             tone_compare;
  } result_t;

  // route state touched by the buttons
  typedef struct packed {
    logic [4:0] station;
    logic       at_station;
    logic       heading;
    logic       door_active;
    logic       chime_kind;
    logic [8:0] chime_step;
  } route_t;

  // effect of one newly pressed button on the route state
  function automatic route_t press_key(route_t r, key_t k);
    route_t n;
    n = r;
    case (k)
      KEY_DOOR: begin
        n.door_active = ~r.door_active;
      end
      KEY_CHIME1: begin
        n.chime_kind = 1'b0;
        n.chime_step = '0;
      end
      KEY_CHIME2: begin
        n.chime_kind = 1'b1;
        n.chime_step = '0;
      end
      KEY_FWD: begin
        if (!(r.station == LAST_STATION && r.at_station)) begin
          if (r.at_station ^ r.heading) n.station = r.station + 5'd1;
          n.at_station = ~r.at_station;
        end
      end
      KEY_REVERSE: begin
        if (r.station == FIRST_STATION || r.station == LAST_STATION) n.at_station = 1'b1;
        n.heading = ~r.heading;
      end
      KEY_BACK: begin
        if (!(r.station == FIRST_STATION && r.at_station)) begin
          if (!(r.at_station ^ r.heading)) n.station = r.station - 5'd1;
          n.at_station = ~r.at_station;
        end
      end
      default: begin
        n = r;
      end
    endcase
    return n;
  endfunction

endpackage

[sv/route_indicator_controller.sv]
// route indicator controller: chime, button debounce, station tracking and lamp frame
//
// Usage: ticks arrive on the tick channel (tick_valid / tick_stall / tick).
// A tick with cmd 0 is the chime and key tick: it advances the chime by one
// step and, every second such tick, samples and debounces the six active-low
// buttons and acts on newly pressed ones. A tick with cmd 1 is the display
// refresh: it toggles the blink phase and rebuilds the 40-lamp frame, the
// door lamp and the direction arrows.
// Every tick gives exactly one item on the result channel (res_valid /
// res_stall / res) holding the current lamp and tone outputs.
// The input register takes the tick when it is accepted, and the result register
// takes its result when the receiver does not stall, so res_valid is registered.
// Throughput: one tick per cycle while the receiver does not stall, set by the
// single pass of logic between the two registers.
// When the receiver stalls, the result is held and one more tick can still
// be taken into the input register; tick_stall rises only when both are full.
// Reset: station 1 at the platform, heading 0, door off, chime silent,
// outputs cleared with the tone period at 99; no items are pending.
module route_indicator_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            tick_valid,
  output logic            tick_stall,
  input  ric_pkg::tick_t  tick,
  output logic            res_valid,
  input  logic            res_stall,
  output ric_pkg::result_t res
);
  import ric_pkg::*;

  // pipeline control
  logic    s1_valid;
  tick_t   s1_tick;
  logic    out_free;
  logic    s1_go;

  // block state
  route_t  route;
  logic    blink_phase;
  logic    sample_divider;
  logic [5:0] prev_sample;
  logic [5:0] older_sample;
  logic [5:0] stable_keys;
  logic [5:0] armed_keys;
  result_t held;

  // next values
  route_t  route_next;
  logic    blink_phase_next;
  logic    sample_divider_next;
  logic [5:0] prev_sample_next;
  logic [5:0] older_sample_next;
  logic [5:0] stable_keys_next;
  logic [5:0] armed_keys_next;
  result_t held_next;

  assign out_free   = !res_valid || !res_stall;
  assign s1_go      = s1_valid && out_free;
  assign tick_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!tick_stall) begin
      s1_valid <= tick_valid;
    end
    if (!tick_stall && tick_valid) begin
      s1_tick <= tick;
    end
  end

  // one pass over the registered tick
  always_comb begin
    logic [5:0] smp;
    logic       lit;
    logic [7:0] pos;
    logic [7:0] mid;
    logic [FRAME_LAMPS-1:0] f;

    route_next          = route;
    blink_phase_next    = blink_phase;
    sample_divider_next = sample_divider;
    prev_sample_next    = prev_sample;
    older_sample_next   = older_sample;
    stable_keys_next    = stable_keys;
    armed_keys_next     = armed_keys;
    held_next           = held;
    smp = ~s1_tick.buttons_n;
    lit = 1'b0;
    pos = '0;
    mid = '0;
    f   = '0;

    if (s1_tick.cmd == CMD_REFRESH) begin
      // blink toggle and lamp frame
      blink_phase_next = ~blink_phase;
      lit = blink_phase;
      held_next.door_lamp = lit & route.door_active;
      pos = ({3'b000, route.station} + 8'd1) << 1;
      mid = (route.heading ^ route.at_station) ? pos + 8'd1 : pos - 8'd1;
      for (int i = 0; i < FRAME_LAMPS; i++) begin
        if (pos == 8'(i + 1) && (route.at_station || lit)) f[i] = 1'b1;
        else if (mid == 8'(i + 1) && (!route.at_station || lit)) f[i] = 1'b1;
      end
      held_next.lamp_frame = f;
      held_next.arrow_a = ~route.heading;
      held_next.arrow_b = route.heading;
    end else begin
      // chime step
      if (route.chime_step < CHIME_END) begin
        if (route.chime_step < HIGH1_END ||
            (route.chime_step >= HIGH2_START && route.chime_step < LOW2_START)) begin
          held_next.tone_period  = route.chime_kind ? HIGH_PERIOD_1 : HIGH_PERIOD_0;
          held_next.tone_compare = route.chime_kind ? HIGH_CMP_1 : HIGH_CMP_0;
        end else if (route.chime_step < LOW1_END || route.chime_step >= LOW2_START) begin
          held_next.tone_period  = route.chime_kind ? LOW_PERIOD_1 : LOW_PERIOD_0;
          held_next.tone_compare = route.chime_kind ? LOW_CMP_1 : LOW_CMP_0;
        end else begin
          held_next.tone_compare = '0;
        end
        route_next.chime_step = route.chime_step + 9'd1;
      end else begin
        held_next.tone_compare = '0;
      end

      // button sample every second chime tick
      sample_divider_next = ~sample_divider;
      if (sample_divider) begin
        if (smp == prev_sample) begin
          if (prev_sample == older_sample) stable_keys_next = smp;
          else older_sample_next = prev_sample;
        end else begin
          prev_sample_next = smp;
        end
        for (int k = 0; k < 6; k++) begin
          if (stable_keys_next[k] && armed_keys_next[k]) begin
            armed_keys_next[k] = 1'b0;
            route_next = press_key(route_next, key_t'(3'(k)));
          end else if (!stable_keys_next[k] && !armed_keys_next[k]) begin
            armed_keys_next[k] = 1'b1;
          end
        end
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      route.station     <= FIRST_STATION;
      route.at_station  <= 1'b1;
      route.heading     <= 1'b0;
      route.door_active <= 1'b0;
      route.chime_kind  <= 1'b0;
      route.chime_step  <= CHIME_END;
      blink_phase       <= 1'b0;
      sample_divider    <= 1'b0;
      prev_sample       <= '0;
      older_sample      <= '0;
      stable_keys       <= '0;
      armed_keys        <= '1;
      held.lamp_frame   <= '0;
      held.door_lamp    <= 1'b0;
      held.arrow_a      <= 1'b0;
      held.arrow_b      <= 1'b0;
      held.tone_period  <= RESET_PERIOD;
      held.tone_compare <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (s1_go) begin
        route          <= route_next;
        blink_phase    <= blink_phase_next;
        sample_divider <= sample_divider_next;
        prev_sample    <= prev_sample_next;
        older_sample   <= older_sample_next;
        stable_keys    <= stable_keys_next;
        armed_keys     <= armed_keys_next;
        held           <= held_next;
      end
      if (out_free) begin
        res_valid <= s1_valid;
      end
    end
    if (s1_go) begin
      res <= held_next;
    end
  end

endmodule

[tb/route_indicator_controller_test.sv]
// self-checking testbench for the route indicator controller
`timescale 1ns / 1ps

module route_indicator_controller_test;
  import ric_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1500;

  logic    clk;
  logic    rst;
  logic    tick_valid;
  logic    tick_stall;
  tick_t   tick_in;
  logic    res_valid;
  logic    res_stall;
  result_t res_out;

  route_indicator_controller uut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick_in),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res_out)
  );

  // predicted indicator state
  logic [4:0] station;
  logic       at_station;
  logic       heading;
  logic       door_active;
  logic       blink_phase;
  logic       chime_kind;
  logic [8:0] chime_step;
  logic       sample_due;
  logic [5:0] prev_smp;
  logic [5:0] older_smp;
  logic [5:0] stable_keys;
  logic [5:0] armed_keys;
  result_t    ind_out;

  result_t    due_outputs[$];
  int         errors;
  int         items_sent;
  int         cycles;
  logic       no_idle;
  logic       going_up;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // predict the outputs held after one accepted item
  task automatic predict_indicator(input tick_t t);
    logic       lit;
    logic [5:0] s;
    logic [5:0] b;
    int         pos;
    int         mid;
    if (t.cmd == CMD_REFRESH) begin
      // blink toggle and lamp frame rebuild
      blink_phase = ~blink_phase;
      lit = ~blink_phase;
      ind_out.door_lamp = lit & door_active;
      pos = (int'(station) + 1) * 2;
      mid = pos + ((heading ^ at_station) ? 1 : -1);
      for (int i = 1; i <= FRAME_LAMPS; i++) begin
        ind_out.lamp_frame[i-1] = (pos == i && (at_station || lit)) ||
                                  (mid == i && (!at_station || lit));
      end
      ind_out.arrow_a = ~heading;
      ind_out.arrow_b = heading;
    end else begin
      // one chime step
      if (chime_step < CHIME_END) begin
        if (chime_step < HIGH1_END || (chime_step >= HIGH2_START && chime_step < LOW2_START)) begin
          ind_out.tone_period  = chime_kind ? HIGH_PERIOD_1 : HIGH_PERIOD_0;
          ind_out.tone_compare = chime_kind ? HIGH_CMP_1 : HIGH_CMP_0;
        end else if (chime_step < LOW1_END || chime_step >= LOW2_START) begin
          ind_out.tone_period  = chime_kind ? LOW_PERIOD_1 : LOW_PERIOD_0;
          ind_out.tone_compare = chime_kind ? LOW_CMP_1 : LOW_CMP_0;
        end else begin
          ind_out.tone_compare = '0;
        end
        chime_step = chime_step + 9'd1;
      end else begin
        ind_out.tone_compare = '0;
      end
      // buttons sampled on every second chime tick
      if (sample_due) begin
        sample_due = 1'b0;
        s = ~t.buttons_n;
        if (s == prev_smp) begin
          if (prev_smp == older_smp) stable_keys = s;
          else older_smp = prev_smp;
        end else begin
          prev_smp = s;
        end
        for (int k = 0; k < 6; k++) begin
          b = 6'd1 << k;
          if ((stable_keys & b & armed_keys) != '0) begin
            armed_keys = armed_keys & ~b;
            case (key_t'(k))
              KEY_DOOR: begin
                door_active = ~door_active;
              end
              KEY_CHIME1: begin
                chime_kind = 1'b0;
                chime_step = '0;
              end
              KEY_CHIME2: begin
                chime_kind = 1'b1;
                chime_step = '0;
              end
              KEY_FWD: begin
                if (!(station == LAST_STATION && at_station)) begin
                  if (at_station ^ heading) station = station + 5'd1;
                  at_station = ~at_station;
                end
              end
              KEY_REVERSE: begin
                if (station == FIRST_STATION || station == LAST_STATION) at_station = 1'b1;
                heading = ~heading;
              end
              KEY_BACK: begin
                if (!(station == FIRST_STATION && at_station)) begin
                  if (!(at_station ^ heading)) station = station - 5'd1;
                  at_station = ~at_station;
                end
              end
              default: begin
              end
            endcase
          end else if (((stable_keys | armed_keys) & b) == '0) begin
            // re-arm on release
            armed_keys = armed_keys | b;
          end
        end
      end else begin
        sample_due = 1'b1;
      end
    end
    due_outputs.push_back(ind_out);
  endtask

  // send one item, with random idle cycles in front of it
  task automatic send_tick(input logic cmd, input logic [5:0] pins);
    tick_t t;
    t.cmd = cmd;
    t.buttons_n = pins;
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_in <= t;
    do begin
      @(posedge clk);
    end while (tick_stall);
    predict_indicator(t);
    items_sent++;
  endtask

  // hold the pins over a number of chime ticks, refreshes mixed in
  task automatic hold_buttons(input logic [5:0] pins, input int chimes, input int refresh_pct);
    repeat (chimes) begin
      if ($urandom_range(0, 99) < refresh_pct) send_tick(CMD_REFRESH, 6'($urandom));
      send_tick(CMD_CHIME, pins);
    end
  endtask

  // result checker with random receiver stalls
  initial begin
    result_t e;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (due_outputs.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          e = due_outputs.pop_front();
          if (res_out.lamp_frame !== e.lamp_frame) begin
            $error("lamp_frame expected %h actual %h", e.lamp_frame, res_out.lamp_frame);
            errors++;
          end
          if (res_out.door_lamp !== e.door_lamp) begin
            $error("door_lamp expected %b actual %b", e.door_lamp, res_out.door_lamp);
            errors++;
          end
          if (res_out.arrow_a !== e.arrow_a) begin
            $error("arrow_a expected %b actual %b", e.arrow_a, res_out.arrow_a);
            errors++;
          end
          if (res_out.arrow_b !== e.arrow_b) begin
            $error("arrow_b expected %b actual %b", e.arrow_b, res_out.arrow_b);
            errors++;
          end
          if (res_out.tone_period !== e.tone_period) begin
            $error("tone_period expected %0d actual %0d", e.tone_period, res_out.tone_period);
            errors++;
          end
          if (res_out.tone_compare !== e.tone_compare) begin
            $error("tone_compare expected %0d actual %0d", e.tone_compare, res_out.tone_compare);
            errors++;
          end
        end
      end
      res_stall <= !no_idle && ($urandom_range(0, 99) < 28);
    end
  end

  // outputs straight after reset: silent chime, empty frame
  task automatic check_reset_outputs();
    send_tick(CMD_CHIME, 6'h00);
    send_tick(CMD_REFRESH, 6'h3f);
  endtask

  // all six buttons pressed together are handled in order, then released
  task automatic check_all_keys_together();
    hold_buttons(6'h00, 6, 0);
    send_tick(CMD_REFRESH, 6'h00);
    hold_buttons(6'h3f, 6, 0);
    send_tick(CMD_REFRESH, 6'h3f);
  endtask

  // blink phase alternation with door lamp and arrows
  task automatic check_blink_and_arrows();
    send_tick(CMD_REFRESH, 6'h2a);
    send_tick(CMD_REFRESH, 6'h15);
    send_tick(CMD_CHIME, 6'h3f);
  endtask

  // random journeys: clean presses and releases, bounces and quiet stretches
  task automatic run_random_journeys();
    int         r;
    int         k;
    logic [5:0] mask;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (items_sent >= 500 && items_sent < 800);
      if (station == LAST_STATION && at_station) going_up = 1'b0;
      if (station == FIRST_STATION && at_station) going_up = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        // long quiet stretch in which the chime can play out to silence
        hold_buttons(6'h3f, $urandom_range(150, 300), 10);
      end else if (r < 18) begin
        // noise and bounces
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)), 6'($urandom));
      end else if (r < 24) begin
        // press too short to debounce
        hold_buttons(~6'($urandom_range(1, 63)), $urandom_range(1, 4), 20);
        hold_buttons(6'h3f, $urandom_range(1, 4), 20);
      end else begin
        // clean press then release
        k = $urandom_range(0, 99);
        if (k < 10) mask = 6'd1 << KEY_DOOR;
        else if (k < 16) mask = 6'd1 << KEY_CHIME1;
        else if (k < 22) mask = 6'd1 << KEY_CHIME2;
        else if (k < 34) mask = 6'd1 << KEY_REVERSE;
        else if (k < 44) mask = 6'($urandom_range(1, 63));
        else if (k < 52) mask = 6'd1 << (going_up ? KEY_BACK : KEY_FWD);
        else mask = 6'd1 << (going_up ? KEY_FWD : KEY_BACK);
        hold_buttons(~mask, $urandom_range(6, 8), 20);
        hold_buttons(6'h3f, $urandom_range(6, 8), 20);
      end
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst <= 1'b1;
    tick_valid <= 1'b0;
    tick_in <= '0;
    errors = 0;
    items_sent = 0;
    no_idle = 1'b0;
    going_up = 1'b1;
    station = FIRST_STATION;
    at_station = 1'b1;
    heading = 1'b0;
    door_active = 1'b0;
    blink_phase = 1'b0;
    chime_kind = 1'b0;
    chime_step = CHIME_END;
    sample_due = 1'b0;
    prev_smp = '0;
    older_smp = '0;
    stable_keys = '0;
    armed_keys = '1;
    ind_out = '0;
    ind_out.tone_period = RESET_PERIOD;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    check_reset_outputs();
    check_all_keys_together();
    check_blink_and_arrows();
    run_random_journeys();

    tick_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && due_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
